[src/rsltab_pkg.sv]
// Shared types, constants and codes of the retransmit slot table.
package rsltab_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] MAX_RETRIES_RST = 8'd3;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        K_ADDED      = 3'd0,
        K_FULL       = 3'd1,
        K_REMOVED    = 3'd2,
        K_NOT_FOUND  = 3'd3,
        K_RETRANSMIT = 3'd4,
        K_EXPIRED    = 3'd5,
        K_TICK_IDLE  = 3'd6,
        K_BAD        = 3'd7
    } t_kind;

    typedef struct packed {
        logic [7:0]  len;
        logic [7:0]  ident;
        logic [7:0]  retries;
        logic [15:0] reload;
        logic [15:0] countdown;
    } t_slot;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        t_slot            data;
    } t_slot_wr;

    // Outcome of evaluating one slot against the current request.
    typedef struct packed {
        logic       result;
        logic       write;
        t_slot      slot;
        t_kind      kind;
        logic [7:0] res_id;
        logic [7:0] res_len;
        logic [7:0] retry;
        logic       inc;
        logic       dec;
    } t_eval;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] slot;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] retry;
        logic [3:0] occ;
    } t_result;

endpackage

[src/retransmit_slot_table.sv]
// An add or remove scans slots in order up to the match; a rejected request skips the scan.
// A tick scans every slot, one per cycle unless a new result must wait for the output.
// The single slot-evaluation unit serves every slot in turn; output back-pressure adds stalls, and a
// new request is accepted only in idle, once the previous one's final result is registered.
// Reset (synchronous, active low) frees all slots, clears the count and sets
// max_retries to 3.
module retransmit_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // packet_id[7:0], packet_length[15:8], retry_timeout[31:16]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // slot_index[2:0], result_id[10:3], result_length[18:11],
                                     // retry_number[26:19], occupied[30:27], zero[31]
    output logic [2:0]  o_m_tuser,   // result_kind[2:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    rsltab_pkg::t_op                r_op, n_op;
    logic [7:0]                     r_id, n_id;
    logic [7:0]                     r_len, n_len;
    logic [15:0]                    r_tmo, n_tmo;
    logic [rsltab_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [rsltab_pkg::CNT_W-1:0]   r_occ, n_occ;
    logic [rsltab_pkg::NRES_W-1:0]  r_nres, n_nres;
    logic                           r_pend_valid, n_pend_valid;
    rsltab_pkg::t_result            r_pend, n_pend;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_last, n_out_last;
    rsltab_pkg::t_result            r_out, n_out;
    logic [7:0]                     r_max_retries;

    rsltab_pkg::t_slot    rd_slot;
    rsltab_pkg::t_slot_wr wr;
    rsltab_pkg::t_eval    ev;
    logic                 out_free;
    logic                 last_idx;
    logic                 cap_reached;
    logic [rsltab_pkg::CNT_W-1:0] occ_after;
    rsltab_pkg::t_result  ev_res;
    rsltab_pkg::t_result  idle_res;
    logic                 bad_req;
    rsltab_pkg::t_op      in_op;

    rsltab_slots u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_idx),
        .o_rd_data (rd_slot),
        .i_wr      (wr)
    );

    rsltab_unit u_unit (
        .i_op          (r_op),
        .i_id          (r_id),
        .i_len         (r_len),
        .i_tmo         (r_tmo),
        .i_max_retries (r_max_retries),
        .i_cap_reached (cap_reached),
        .i_slot        (rd_slot),
        .o_eval        (ev)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out.kind;
    assign o_m_tlast   = r_out_last;
    assign o_m_tdata   = {1'b0, r_out.occ, r_out.retry, r_out.len, r_out.id, r_out.slot};

    assign out_free    = !r_out_valid || i_m_tready;
    assign last_idx    = (r_idx == rsltab_pkg::IDX_W'(rsltab_pkg::NUM_SLOTS - 1));
    assign cap_reached = (r_nres >= rsltab_pkg::NRES_W'(rsltab_pkg::MAX_RESULTS));
    assign in_op       = rsltab_pkg::t_op'(i_s_tuser);

    always_comb begin
        if (ev.inc) begin
            occ_after = r_occ + 1'b1;
        end else if (ev.dec) begin
            occ_after = r_occ - 1'b1;
        end else begin
            occ_after = r_occ;
        end
    end

    always_comb begin
        ev_res.kind  = ev.kind;
        ev_res.slot  = 3'(r_idx);
        ev_res.id    = ev.res_id;
        ev_res.len   = ev.res_len;
        ev_res.retry = ev.retry;
        ev_res.occ   = 4'(occ_after);
    end

    always_comb begin
        idle_res      = '0;
        idle_res.kind = rsltab_pkg::K_TICK_IDLE;
        idle_res.occ  = 4'(r_occ);
    end

    always_comb begin
        unique case (in_op)
            rsltab_pkg::OP_ADD:    bad_req = (i_s_tdata[7:0] == 8'd0) || (i_s_tdata[15:8] == 8'd0);
            rsltab_pkg::OP_REMOVE: bad_req = (i_s_tdata[7:0] == 8'd0);
            rsltab_pkg::OP_TICK:   bad_req = 1'b0;
            default:               bad_req = 1'b1;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_len        = r_len;
        n_tmo        = r_tmo;
        n_idx        = r_idx;
        n_occ        = r_occ;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_last   = r_out_last;
        n_out        = r_out;
        wr           = '0;
        wr.idx       = r_idx;
        wr.data      = ev.slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op         = in_op;
                    n_id         = i_s_tdata[7:0];
                    n_len        = i_s_tdata[15:8];
                    n_tmo        = i_s_tdata[31:16];
                    n_idx        = '0;
                    n_nres       = '0;
                    n_pend_valid = 1'b0;
                    if (bad_req) begin
                        n_pend.kind  = rsltab_pkg::K_BAD;
                        n_pend.slot  = 3'd0;
                        n_pend.id    = i_s_tdata[7:0];
                        n_pend.len   = i_s_tdata[15:8];
                        n_pend.retry = 8'd0;
                        n_pend.occ   = 4'(r_occ);
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_op == rsltab_pkg::OP_TICK) begin
                    // A new result may need the held one pushed out first.
                    if (!(ev.result && r_pend_valid && !out_free)) begin
                        wr.we = ev.write;
                        n_occ = occ_after;
                        if (ev.result) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out_last  = 1'b0;
                                n_out       = r_pend;
                            end
                            n_pend_valid = 1'b1;
                            n_pend       = ev_res;
                            n_nres       = r_nres + 1'b1;
                        end
                        if (last_idx) begin
                            if (!r_pend_valid && !ev.result) begin
                                n_pend = idle_res;
                            end
                            n_state = S_DONE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end else begin
                    if (ev.result) begin
                        wr.we   = 1'b1;
                        n_occ   = occ_after;
                        n_pend  = ev_res;
                        n_state = S_DONE;
                    end else if (last_idx) begin
                        n_pend.slot  = 3'd0;
                        n_pend.id    = r_id;
                        n_pend.retry = 8'd0;
                        n_pend.occ   = 4'(r_occ);
                        if (r_op == rsltab_pkg::OP_ADD) begin
                            n_pend.kind = rsltab_pkg::K_FULL;
                            n_pend.len  = r_len;
                        end else begin
                            n_pend.kind = rsltab_pkg::K_NOT_FOUND;
                            n_pend.len  = 8'd0;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out        = r_pend;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_occ         <= '0;
            r_nres        <= '0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_max_retries <= rsltab_pkg::MAX_RETRIES_RST;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_max_retries <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_len      <= n_len;
        r_tmo      <= n_tmo;
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_out_last <= n_out_last;
        r_out      <= n_out;
    end

endmodule

[src/rsltab_slots.sv]
// Slot storage: per-slot length, id, retries, reload and countdown registers.
module rsltab_slots (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rsltab_pkg::IDX_W-1:0] i_rd_idx,
    output rsltab_pkg::t_slot           o_rd_data,
    input  rsltab_pkg::t_slot_wr        i_wr
);

    rsltab_pkg::t_slot r_slot [rsltab_pkg::NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rsltab_pkg::NUM_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
        end else if (i_wr.we) begin
            r_slot[i_wr.idx] <= i_wr.data;
        end
    end

    assign o_rd_data = r_slot[i_rd_idx];

endmodule

[src/rsltab_unit.sv]
// Shared evaluation unit: matches, fills, counts down, reloads and retires the slot under scan.
module rsltab_unit (
    input  rsltab_pkg::t_op   i_op,
    input  logic [7:0]        i_id,
    input  logic [7:0]        i_len,
    input  logic [15:0]       i_tmo,
    input  logic [7:0]        i_max_retries,
    input  logic              i_cap_reached,
    input  rsltab_pkg::t_slot i_slot,
    output rsltab_pkg::t_eval o_eval
);

    logic occupied;

    assign occupied = (i_slot.len != 8'd0);

    always_comb begin
        o_eval         = '0;
        o_eval.kind    = rsltab_pkg::K_BAD;
        o_eval.slot    = i_slot;
        o_eval.res_id  = i_slot.ident;
        o_eval.res_len = i_slot.len;
        unique case (i_op)
            rsltab_pkg::OP_ADD: begin
                if (!occupied) begin
                    o_eval.result         = 1'b1;
                    o_eval.write          = 1'b1;
                    o_eval.inc            = 1'b1;
                    o_eval.kind           = rsltab_pkg::K_ADDED;
                    o_eval.slot.len       = i_len;
                    o_eval.slot.ident     = i_id;
                    o_eval.slot.retries   = 8'd0;
                    o_eval.slot.reload    = i_tmo;
                    o_eval.slot.countdown = i_tmo;
                    o_eval.res_id         = i_id;
                    o_eval.res_len        = i_len;
                end
            end
            rsltab_pkg::OP_REMOVE: begin
                if (occupied && i_slot.ident == i_id) begin
                    o_eval.result = 1'b1;
                    o_eval.write  = 1'b1;
                    o_eval.dec    = 1'b1;
                    o_eval.kind   = rsltab_pkg::K_REMOVED;
                    o_eval.slot   = '0;
                    o_eval.res_id = i_id;
                end
            end
            rsltab_pkg::OP_TICK: begin
                if (occupied) begin
                    if (i_slot.countdown > 16'd1) begin
                        o_eval.write          = 1'b1;
                        o_eval.slot.countdown = i_slot.countdown - 16'd1;
                    end else if (!i_cap_reached) begin
                        o_eval.result = 1'b1;
                        o_eval.write  = 1'b1;
                        if (i_slot.retries >= i_max_retries) begin
                            o_eval.dec   = 1'b1;
                            o_eval.kind  = rsltab_pkg::K_EXPIRED;
                            o_eval.retry = i_slot.retries;
                            o_eval.slot  = '0;
                        end else begin
                            o_eval.kind           = rsltab_pkg::K_RETRANSMIT;
                            o_eval.retry          = i_slot.retries + 8'd1;
                            o_eval.slot.retries   = i_slot.retries + 8'd1;
                            o_eval.slot.countdown = i_slot.reload;
                        end
                    end
                end
            end
            default: begin
                o_eval.result = 1'b0;
            end
        endcase
    end

endmodule
